// ----- design/pae_pkg.sv -----
// Package for the polygon area block: widths, stage payload types and the
// saturating arithmetic shared by the pipeline stages. No dependencies.
`timescale 1ns / 1ps

package pae_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int PROD_WIDTH    = 2 * COORD_WIDTH;
  localparam int SUM_WIDTH     = 64;
  localparam int AREA_WIDTH    = SUM_WIDTH - 2;
  localparam int IN_DATA_WIDTH  = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH = ((AREA_WIDTH + 7) / 8) * 8;
  localparam int IN_USER_WIDTH  = 2;
  localparam int USER_EXCL_BIT  = 0;
  localparam int USER_PEND_BIT  = 1;

  localparam logic signed [SUM_WIDTH-1:0] SAT_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SAT_MIN = {1'b1, {(SUM_WIDTH-2){1'b0}}, 1'b1};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

  // Products of one vertex, leaving the multiplier stage
  typedef struct packed {
    prod_t p_prev_a;   // prev_x * y
    prod_t p_prev_b;   // x * prev_y
    prod_t p_close_a;  // x * first_y
    prod_t p_close_b;  // first_x * y
    logic  has_prev;
    logic  pend;
    logic  excl;
    logic  full;
    logic  mapend;
  } cross_t;

  // Closed polygon, partial sum plus the closing edge products
  typedef struct packed {
    sum_t  sum_part;
    prod_t p_close_a;
    prod_t p_close_b;
    logic  excl;
    logic  full;
    logic  mapend;
  } close_t;

  // Finished polygon sum, ready for the running total
  typedef struct packed {
    sum_t sum;
    logic excl;
    logic full;
    logic mapend;
  } poly_t;

  function automatic sum_t sext_prod(input prod_t p);
    sext_prod = {{(SUM_WIDTH-PROD_WIDTH){p[PROD_WIDTH-1]}}, p};
  endfunction

  function automatic sum_t sat_add(input sum_t a, input sum_t b);
    logic [SUM_WIDTH:0] s;
    s = {a[SUM_WIDTH-1], a} + {b[SUM_WIDTH-1], b};
    if (!s[SUM_WIDTH] && s[SUM_WIDTH-1]) begin
      sat_add = SAT_MAX;
    end else if (s[SUM_WIDTH] && (!s[SUM_WIDTH-1] || (s[SUM_WIDTH-2:0] == '0))) begin
      sat_add = SAT_MIN;
    end else begin
      sat_add = s[SUM_WIDTH-1:0];
    end
  endfunction

  // a + p, saturate, then - q, saturate
  function automatic sum_t sat_cross(input sum_t a, input prod_t p, input prod_t q);
    sum_t t;
    t = sat_add(a, sext_prod(p));
    sat_cross = sat_add(t, -sext_prod(q));
  endfunction

endpackage

// ----- design/pae_cross.sv -----
// Input register, vertex tracking (first, previous, count) and the four
// cross-product multipliers. Depends on pae_pkg.
`timescale 1ns / 1ps

module pae_cross (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  pae_pkg::coord_t          coord_x,
  input  pae_pkg::coord_t          coord_y,
  input  logic                     is_exclusion,
  input  logic                     polygon_end,
  input  logic                     map_end,
  output logic                     cross_valid,
  output pae_pkg::cross_t          cross_data
);

  logic            s1_valid;
  pae_pkg::coord_t s1_x;
  pae_pkg::coord_t s1_y;
  logic            s1_excl;
  logic            s1_pend;
  logic            s1_mapend;

  pae_pkg::coord_t first_x;
  pae_pkg::coord_t first_y;
  pae_pkg::coord_t prev_x;
  pae_pkg::coord_t prev_y;
  logic [1:0]      vertex_count;

  logic            has_prev;
  logic            pend_eff;
  pae_pkg::coord_t fx;
  pae_pkg::coord_t fy;
  pae_pkg::cross_t cross_next;

  always_comb begin
    has_prev = (vertex_count != 2'd0);
    pend_eff = s1_pend | s1_mapend;
    fx       = has_prev ? first_x : s1_x;
    fy       = has_prev ? first_y : s1_y;
    cross_next.p_prev_a  = prev_x * s1_y;
    cross_next.p_prev_b  = s1_x * prev_y;
    cross_next.p_close_a = s1_x * fy;
    cross_next.p_close_b = fx * s1_y;
    cross_next.has_prev  = has_prev;
    cross_next.pend      = pend_eff;
    cross_next.excl      = s1_excl;
    cross_next.full      = vertex_count[1];
    cross_next.mapend    = s1_mapend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      cross_valid  <= 1'b0;
      vertex_count <= 2'd0;
    end else if (en) begin
      s1_valid    <= in_valid;
      cross_valid <= s1_valid;
      if (s1_valid) begin
        if (pend_eff) begin
          vertex_count <= 2'd0;
        end else if (vertex_count != 2'd3) begin
          vertex_count <= vertex_count + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x       <= coord_x;
      s1_y       <= coord_y;
      s1_excl    <= is_exclusion;
      s1_pend    <= polygon_end;
      s1_mapend  <= map_end;
      cross_data <= cross_next;
      if (s1_valid) begin
        prev_x <= s1_x;
        prev_y <= s1_y;
        if (!has_prev) begin
          first_x <= s1_x;
          first_y <= s1_y;
        end
      end
    end
  end

endmodule

// ----- design/pae_accum.sv -----
// Polygon sum accumulator and closing-edge stage: saturating sums of the
// cross products, one finished sum per closed polygon. Depends on pae_pkg.
`timescale 1ns / 1ps

module pae_accum (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            cross_valid,
  input  pae_pkg::cross_t cross_data,
  output logic            poly_valid,
  output pae_pkg::poly_t  poly
);

  pae_pkg::sum_t   polygon_sum;
  pae_pkg::sum_t   polygon_sum_next;
  logic            close_valid;
  pae_pkg::close_t close_q;
  pae_pkg::close_t close_next;
  pae_pkg::poly_t  poly_next;

  always_comb begin
    polygon_sum_next = cross_data.has_prev ?
        pae_pkg::sat_cross(polygon_sum, cross_data.p_prev_a,
                           cross_data.p_prev_b) : polygon_sum;
    close_next.sum_part  = polygon_sum_next;
    close_next.p_close_a = cross_data.p_close_a;
    close_next.p_close_b = cross_data.p_close_b;
    close_next.excl      = cross_data.excl;
    close_next.full      = cross_data.full;
    close_next.mapend    = cross_data.mapend;
    poly_next.sum    = pae_pkg::sat_cross(close_q.sum_part, close_q.p_close_a,
                                          close_q.p_close_b);
    poly_next.excl   = close_q.excl;
    poly_next.full   = close_q.full;
    poly_next.mapend = close_q.mapend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      polygon_sum <= '0;
      close_valid <= 1'b0;
      poly_valid  <= 1'b0;
    end else if (en) begin
      close_valid <= cross_valid & cross_data.pend;
      poly_valid  <= close_valid;
      if (cross_valid) begin
        polygon_sum <= cross_data.pend ? '0 : polygon_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      close_q <= close_next;
      poly    <= poly_next;
    end
  end

endmodule

// ----- design/pae_total.sv -----
// Running map total, end-of-map halving and clamp, and the result register
// with its stall control. Depends on pae_pkg.
`timescale 1ns / 1ps

module pae_total (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           poly_valid,
  input  pae_pkg::poly_t                 poly,
  input  logic                           out_ready,
  output logic                           en,
  output logic                           out_valid,
  output logic [pae_pkg::AREA_WIDTH-1:0] out_area,
  output logic                           out_map_valid
);

  pae_pkg::sum_t area_total;
  logic          perimeter_ok;
  pae_pkg::sum_t delta;
  pae_pkg::sum_t total_next;
  logic          perimeter_ok_next;
  logic          total_pos;

  always_comb begin
    en = !(poly_valid && poly.mapend && out_valid && !out_ready);
    delta = (poly.sum[pae_pkg::SUM_WIDTH-1] ^ poly.excl) ? -poly.sum : poly.sum;
    total_next = poly.full ? pae_pkg::sat_add(area_total, delta) : area_total;
    perimeter_ok_next = perimeter_ok | (poly.full & ~poly.excl);
    total_pos = !total_next[pae_pkg::SUM_WIDTH-1] && (total_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_total   <= '0;
      perimeter_ok <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (en && poly_valid) begin
        if (poly.mapend) begin
          area_total   <= '0;
          perimeter_ok <= 1'b0;
          out_valid    <= 1'b1;
        end else begin
          area_total   <= total_next;
          perimeter_ok <= perimeter_ok_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && poly_valid && poly.mapend) begin
      out_area      <= total_pos ? total_next[pae_pkg::SUM_WIDTH-2:1] : '0;
      out_map_valid <= perimeter_ok_next;
    end
  end

endmodule

// ----- design/polygon_area_with_exclusions_top.sv -----
// Net map area from a stream of polygon vertices by the shoelace formula.
// Instantiates pae_cross, pae_accum and pae_total; depends on pae_pkg.
`timescale 1ns / 1ps

// One vertex is taken per clock cycle unless input is held off. The map-closing
// vertex passes the input, product, closing-edge and polygon-sum registers, then
// the result register. Input is held off only while a map result sits in the last
// stage and the previous result has not yet been taken; the polygon-sum accumulator
// sets the vertex rate. Coordinates are signed Q15.8, the area is unsigned Q46.16
// square metres, clamped at zero; map_valid is set when a perimeter polygon had at
// least three vertices. map_end also closes the open polygon.
module polygon_area_with_exclusions_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [pae_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata,  // coord_x, coord_y
  input  logic [pae_pkg::IN_USER_WIDTH-1:0]  s_axis_tuser,  // is_exclusion, polygon_end
  input  logic                               s_axis_tlast,  // map_end
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [pae_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata,  // area, zero fill
  output logic                               m_axis_tuser   // map_valid
);

  logic                           en;
  logic                           cross_valid;
  pae_pkg::cross_t                cross_data;
  logic                           poly_valid;
  pae_pkg::poly_t                 poly;
  logic [pae_pkg::AREA_WIDTH-1:0] area;

  assign s_axis_tready = en;
  assign m_axis_tdata  = {{(pae_pkg::OUT_DATA_WIDTH-pae_pkg::AREA_WIDTH){1'b0}}, area};

  pae_cross u_cross (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s_axis_tvalid),
    .coord_x      ($signed(s_axis_tdata[pae_pkg::COORD_WIDTH-1:0])),
    .coord_y      ($signed(s_axis_tdata[2*pae_pkg::COORD_WIDTH-1:pae_pkg::COORD_WIDTH])),
    .is_exclusion (s_axis_tuser[pae_pkg::USER_EXCL_BIT]),
    .polygon_end  (s_axis_tuser[pae_pkg::USER_PEND_BIT]),
    .map_end      (s_axis_tlast),
    .cross_valid  (cross_valid),
    .cross_data   (cross_data)
  );

  pae_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cross_valid (cross_valid),
    .cross_data  (cross_data),
    .poly_valid  (poly_valid),
    .poly        (poly)
  );

  pae_total u_total (
    .clk           (clk),
    .rst           (rst),
    .poly_valid    (poly_valid),
    .poly          (poly),
    .out_ready     (m_axis_tready),
    .en            (en),
    .out_valid     (m_axis_tvalid),
    .out_area      (area),
    .out_map_valid (m_axis_tuser)
  );

endmodule

// ----- design/pae_checker.sv -----
// Port-level checks for the polygon area block, bound to its top level.
// Depends on pae_pkg and polygon_area_with_exclusions_top.
`timescale 1ns / 1ps

module pae_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [pae_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata,
  input logic                               m_axis_tuser
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_no_perimeter_no_area: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("area without a valid perimeter");

  a_area_range: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid |->
      m_axis_tdata[pae_pkg::OUT_DATA_WIDTH-1:pae_pkg::AREA_WIDTH] == '0)
    else $error("area above its range");

endmodule

bind polygon_area_with_exclusions_top pae_checker u_pae_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
